/* rtl/dcq_pkg.sv */
// types, register map constants and layout table for the dma command-queue register bank
package dcq_pkg;

   localparam logic [31:0] PTR_MASK   = 32'h0003_FFFF;
   localparam logic [31:0] RDP_MAGIC  = 32'hEE88_2266;
   localparam logic [31:0] STAT_RESET = 32'hF800_0000;

   // word indices below this bound live in flops, the rest in the memory
   localparam int unsigned LO_WORDS = 16;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [9:0]  word_index;
      logic [31:0] write_data;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
   } rsp_word_type;

   typedef struct packed {
      logic [3:0]  endp;
      logic [3:0]  wrp;
      logic [3:0]  rdp;
      logic [3:0]  ctrl;
      logic [3:0]  status;
      logic [31:0] ctrl_mask;
      logic [31:0] complete;
   } layout_type;

   // reset layout puts status at word 9
   localparam logic [3:0] RESET_STATUS_IDX = 4'd9;

   function automatic layout_type layout_of(input logic variant);
      layout_type lay;
      if (variant) begin
         lay = '{endp: 4'd6, wrp: 4'd7, rdp: 4'd8, ctrl: 4'd14, status: 4'd15,
                 ctrl_mask: 32'h0170_03FF, complete: 32'h0003_0000};
      end else begin
         lay = '{endp: 4'd5, wrp: 4'd6, rdp: 4'd7, ctrl: 4'd8, status: 4'd9,
                 ctrl_mask: 32'hBFEF_F07F, complete: 32'h0000_0030};
      end
      return lay;
   endfunction

   typedef struct packed {
      logic accept;
      logic exec;
      logic clr_step;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
   } sts_type;

endpackage

/* rtl/dma_cmdq_pointer_irq_regs.sv */
// top level of the dma command-queue pointer and interrupt register bank
// usage: drive req_word and pulse start while busy is low; that edge accepts
// one read or write word. the controller then runs its execute state, and the
// result word (read data, interrupt level) shows on rsp_word for exactly one
// cycle with rsp_strobe high, starting at the edge that ends the execute
// state, and is taken at the edge that ends that cycle.
// busy covers the execute state, and a new word may be accepted at the edge
// that ends the cycle the previous result is shown; no new word is taken
// while one is in its execute state.
// the receiver has no back-pressure: it must take each result as it appears.
// csr_we/csr_wdata write the layout select bit; write it only while idle.
// after reset the bank is zero except the status word (0xF8000000), the
// magic flag and interrupt are clear, and layout 0 is in force. the upper
// words (index 16 and up) are cleared by a pass over the upper-word memory,
// during which busy stays high.
module dma_cmdq_pointer_irq_regs #(
   parameter int NUM_WORDS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  dcq_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output dcq_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic                  csr_wdata
);

   dcq_pkg::cmd_type cmd;
   dcq_pkg::sts_type sts;

   dcq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .sts        (sts)
   );

   dcq_datapath #(
      .NUM_WORDS (NUM_WORDS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

endmodule

/* rtl/dcq_ctrl.sv */
// controller state machine: memory clearing pass, accept and execute sequencing
module dcq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   output dcq_pkg::cmd_type cmd,
   input  dcq_pkg::sts_type sts
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_strobe_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         busy_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= (state_in != ST_IDLE);
         rsp_strobe_ff <= (state_ff == ST_EXEC);
      end
   end

   assign busy         = busy_ff;
   assign rsp_strobe   = rsp_strobe_ff;
   assign cmd.accept   = start && !busy_ff;
   assign cmd.exec     = (state_ff == ST_EXEC);
   assign cmd.clr_step = (state_ff == ST_CLEAR);

endmodule

/* rtl/dcq_datapath.sv */
// register bank datapath: special words in flops, upper words in a memory, access rules
module dcq_datapath #(
   parameter int NUM_WORDS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dcq_pkg::cmd_type      cmd,
   output dcq_pkg::sts_type      sts,
   input  dcq_pkg::req_word_type req_word,
   output dcq_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic                  csr_wdata
);

   localparam int MEM_DEPTH = (NUM_WORDS > dcq_pkg::LO_WORDS) ?
                              (NUM_WORDS - dcq_pkg::LO_WORDS) : 1;
   localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam logic [10:0] NW = 11'(NUM_WORDS);
   localparam logic [MAW-1:0] CLR_LAST = MAW'(MEM_DEPTH - 1);

   dcq_pkg::req_word_type req_ff;
   dcq_pkg::rsp_word_type rsp_ff, rsp_in;
   logic [31:0]           lo_ff [dcq_pkg::LO_WORDS];
   logic [31:0]           lo_in [dcq_pkg::LO_WORDS];
   logic [31:0]           mem_ff [MEM_DEPTH];
   logic [31:0]           mem_rdata_ff;
   logic [MAW-1:0]        clr_cnt_ff;
   logic                  flag_ff, flag_in;
   logic                  irq_ff, irq_in;
   logic                  layout_ff;

   dcq_pkg::layout_type lay;
   logic [3:0]          w;
   logic                in_lo, in_mem, is_wr;
   logic [31:0]         d;
   logic [MAW-1:0]      mem_ra, mem_xa, mem_wa;
   logic                mem_we;
   logic [31:0]         mem_wd;

   assign lay    = dcq_pkg::layout_of(layout_ff);
   assign w      = req_ff.word_index[3:0];
   assign d      = req_ff.write_data;
   assign is_wr  = (req_ff.req_type == dcq_pkg::REQ_WRITE);
   assign in_lo  = (req_ff.word_index[9:4] == 6'd0);
   assign in_mem = !in_lo && ({1'b0, req_ff.word_index} < NW);

   assign mem_ra = MAW'(req_word.word_index - 10'd16);
   assign mem_xa = MAW'(req_ff.word_index - 10'd16);

   // access rules on the flop-held words
   always_comb begin
      lo_in   = lo_ff;
      flag_in = flag_ff;
      irq_in  = irq_ff;
      if (cmd.exec && is_wr && in_lo) begin
         if (w == lay.endp) begin
            lo_in[w] = d & dcq_pkg::PTR_MASK;
         end else if (w == lay.wrp) begin
            lo_in[lay.wrp] = d & dcq_pkg::PTR_MASK;
            lo_in[lay.rdp] = d & dcq_pkg::PTR_MASK;
            if (flag_ff) begin
               flag_in = 1'b0;
            end else begin
               lo_in[lay.status] = lo_ff[lay.status] | lay.complete;
               if ((lo_ff[lay.ctrl] & lay.complete) != 32'd0) irq_in = 1'b1;
            end
         end else if (w == lay.rdp) begin
            if (d == dcq_pkg::RDP_MAGIC) flag_in = 1'b1;
         end else if (w == lay.ctrl) begin
            lo_in[w] = d & lay.ctrl_mask;
         end else if (w == lay.status) begin
            if ((d & lay.complete) != 32'd0) begin
               lo_in[w] = lo_ff[w] & ~lay.complete;
               irq_in   = 1'b0;
            end
         end else begin
            lo_in[w] = d;
         end
      end
   end

   always_comb begin
      rsp_in.irq_level = irq_in;
      if (is_wr) begin
         rsp_in.read_data = 32'd0;
      end else if (in_lo) begin
         rsp_in.read_data = lo_ff[w];
      end else if (in_mem) begin
         rsp_in.read_data = mem_rdata_ff;
      end else begin
         rsp_in.read_data = 32'd0;
      end
   end

   // one write port shared by the clearing pass and plain stores
   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_cnt_ff;
      mem_wd = 32'd0;
      if (cmd.clr_step) begin
         mem_we = 1'b1;
      end else if (cmd.exec && is_wr && in_mem) begin
         mem_we = 1'b1;
         mem_wa = mem_xa;
         mem_wd = d;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_wa] <= mem_wd;
      if (cmd.accept) mem_rdata_ff <= mem_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dcq_pkg::LO_WORDS; i++) begin
            lo_ff[i] <= (i == int'(dcq_pkg::RESET_STATUS_IDX)) ? dcq_pkg::STAT_RESET : 32'd0;
         end
         flag_ff    <= 1'b0;
         irq_ff     <= 1'b0;
         layout_ff  <= 1'b0;
         clr_cnt_ff <= '0;
      end else begin
         lo_ff   <= lo_in;
         flag_ff <= flag_in;
         irq_ff  <= irq_in;
         if (csr_we) layout_ff <= csr_wdata;
         if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_word;
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   assign sts.clr_last = (clr_cnt_ff == CLR_LAST);
   assign rsp_word     = rsp_ff;

endmodule

/* bench/dma_cmdq_regs_checker.sv */
// checker for the dma command-queue register bank: predicts each result word and compares
`timescale 1ns / 100ps

module dma_cmdq_regs_checker #(
   parameter int NUM_WORDS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  dcq_pkg::req_word_type req_word,
   input  logic                  rsp_strobe,
   input  dcq_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic                  csr_wdata,
   output int                    mismatch_count,
   output int                    pending_count,
   output int                    checked_count
);

   typedef struct packed {
      logic [4:0]  end_ptr;
      logic [4:0]  wr_ptr;
      logic [4:0]  rd_ptr;
      logic [4:0]  ctl;
      logic [4:0]  sts;
      logic [31:0] ctl_mask;
      logic [31:0] done_bits;
   } regmap_t;

   localparam regmap_t MAP_OLD = '{end_ptr: 5'd5, wr_ptr: 5'd6, rd_ptr: 5'd7, ctl: 5'd8,
                                   sts: 5'd9, ctl_mask: 32'hBFEF_F07F,
                                   done_bits: 32'h0000_0030};
   localparam regmap_t MAP_NEW = '{end_ptr: 5'd6, wr_ptr: 5'd7, rd_ptr: 5'd8, ctl: 5'd14,
                                   sts: 5'd15, ctl_mask: 32'h0170_03FF,
                                   done_bits: 32'h0003_0000};

   logic [31:0] bank_q [NUM_WORDS];
   logic        magic_armed;
   logic        irq_q;
   logic        layout_sel;

   dcq_pkg::rsp_word_type rsp_due_q [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 200)
         $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic clear_bank_state();
      foreach (bank_q[i]) bank_q[i] = '0;
      // the status reset value always sits where the old layout puts status
      bank_q[MAP_OLD.sts] = dcq_pkg::STAT_RESET;
      magic_armed = 1'b0;
      irq_q       = 1'b0;
      layout_sel  = 1'b0;
   endtask

   function automatic dcq_pkg::rsp_word_type bank_access(input dcq_pkg::req_word_type w);
      regmap_t               m;
      int unsigned           idx;
      logic [31:0]           rd;
      dcq_pkg::rsp_word_type r;
      m   = layout_sel ? MAP_NEW : MAP_OLD;
      idx = 32'(w.word_index);
      rd  = '0;
      if (w.req_type == dcq_pkg::REQ_READ) begin
         if (idx < NUM_WORDS) rd = bank_q[idx];
      end else if (idx < NUM_WORDS) begin
         if (idx == m.end_ptr) begin
            bank_q[idx] = w.write_data & dcq_pkg::PTR_MASK;
         end else if (idx == m.wr_ptr) begin
            bank_q[idx]      = w.write_data & dcq_pkg::PTR_MASK;
            bank_q[m.rd_ptr] = w.write_data & dcq_pkg::PTR_MASK;
            if (magic_armed) begin
               magic_armed = 1'b0;
            end else begin
               bank_q[m.sts] = bank_q[m.sts] | m.done_bits;
               if ((bank_q[m.ctl] & m.done_bits) != '0) irq_q = 1'b1;
            end
         end else if (idx == m.rd_ptr) begin
            if (w.write_data == dcq_pkg::RDP_MAGIC) magic_armed = 1'b1;
         end else if (idx == m.ctl) begin
            bank_q[idx] = w.write_data & m.ctl_mask;
         end else if (idx == m.sts) begin
            // write one to clear, only when a completion bit is hit
            if ((w.write_data & m.done_bits) != '0) begin
               bank_q[idx] = bank_q[idx] & ~m.done_bits;
               irq_q       = 1'b0;
            end
         end else begin
            bank_q[idx] = w.write_data;
         end
      end
      r.read_data = rd;
      r.irq_level = irq_q;
      return r;
   endfunction

   always @(posedge clock) begin
      dcq_pkg::rsp_word_type want;
      if (reset) begin
         clear_bank_state();
         rsp_due_q.delete();
         mismatch_count = 0;
         checked_count  = 0;
      end else begin
         // the result shown at this edge belongs to an older word than one accepted now
         if (rsp_strobe) begin
            if (rsp_due_q.size() == 0) begin
               report_mismatch("result word with nothing outstanding", rsp_word.read_data, '0);
            end else begin
               want = rsp_due_q.pop_front();
               if (rsp_word.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_word.read_data, want.read_data);
               if (rsp_word.irq_level !== want.irq_level)
                  report_mismatch("irq_level", {31'b0, rsp_word.irq_level},
                                  {31'b0, want.irq_level});
               checked_count++;
            end
         end
         if (start && !busy) rsp_due_q.push_back(bank_access(req_word));
         if (csr_we) layout_sel = csr_wdata;
      end
      pending_count = rsp_due_q.size();
   end

endmodule

/* bench/tb_dma_cmdq_pointer_irq_regs.sv */
// testbench top for the dma command-queue register bank: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_dma_cmdq_pointer_irq_regs;

   localparam int          BANK_WORDS     = 32;
   localparam int unsigned TOP_INDEX      = 1023;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          PHASES         = 7;
   localparam int          PHASE_WORDS    = 250;
   localparam logic        LAYOUT_OLD     = 1'b0;
   localparam logic        LAYOUT_NEW     = 1'b1;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   dcq_pkg::req_word_type req_word  = '0;
   logic                  rsp_strobe;
   dcq_pkg::rsp_word_type rsp_word;
   logic                  csr_we    = 1'b0;
   logic                  csr_wdata = 1'b0;

   int   mismatch_count;
   int   pending_count;
   int   checked_count;
   int   words_sent = 0;
   int   quiet_cycles = 0;
   logic cur_layout = LAYOUT_OLD;
   logic no_idle = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   dma_cmdq_pointer_irq_regs #(
      .NUM_WORDS(BANK_WORDS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   dma_cmdq_regs_checker #(
      .NUM_WORDS(BANK_WORDS)
   ) i_bank_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .rsp_strobe    (rsp_strobe),
      .rsp_word      (rsp_word),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic maybe_idle();
      int unsigned n;
      if (!no_idle && $urandom_range(99) < 38) begin
         n = $urandom_range(4, 1);
         repeat (n) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
   endtask

   task automatic send_word(input logic kind, input int unsigned idx, input logic [31:0] data);
      @(negedge clock);
      start    <= 1'b1;
      req_word <= '{req_type: kind, word_index: idx[9:0], write_data: data};
      do @(posedge clock); while (busy);
      words_sent++;
      maybe_idle();
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic set_layout(input logic v);
      wait_all_results();
      csr_we     <= 1'b1;
      csr_wdata  <= v;
      cur_layout = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // pointer setup, optional magic arm, write pointer kick, status readback and clear
   task automatic run_sequence();
      dcq_pkg::layout_type m;
      logic [31:0]         d;
      m = dcq_pkg::layout_of(cur_layout);
      if ($urandom_range(1)) begin
         d = $urandom;
         if ($urandom_range(1)) d = d | m.complete;
         send_word(dcq_pkg::REQ_WRITE, m.ctrl, d);
      end
      if ($urandom_range(1)) send_word(dcq_pkg::REQ_WRITE, m.endp, $urandom);
      case ($urandom_range(4))
         0, 1:    send_word(dcq_pkg::REQ_WRITE, m.rdp, dcq_pkg::RDP_MAGIC);
         2:       send_word(dcq_pkg::REQ_WRITE, m.rdp, $urandom);
         default: ;
      endcase
      send_word(dcq_pkg::REQ_WRITE, m.wrp, $urandom);
      if ($urandom_range(2) == 0) send_word(dcq_pkg::REQ_READ, m.rdp, $urandom);
      if ($urandom_range(1)) send_word(dcq_pkg::REQ_READ, m.status, $urandom);
      if ($urandom_range(1)) begin
         d = $urandom;
         case ($urandom_range(2))
            0:       d = d & ~m.complete;
            1:       d = d | m.complete;
            default: ;
         endcase
         send_word(dcq_pkg::REQ_WRITE, m.status, d);
      end
      send_word(dcq_pkg::REQ_READ, m.status, $urandom);
   endtask

   task automatic run_single();
      int unsigned idx;
      logic [31:0] d;
      if ($urandom_range(99) < 15) idx = $urandom_range(TOP_INDEX, 0);
      else idx = $urandom_range(BANK_WORDS - 1, 0);
      d = ($urandom_range(9) == 0) ? dcq_pkg::RDP_MAGIC : $urandom;
      send_word($urandom_range(1) ? dcq_pkg::REQ_WRITE : dcq_pkg::REQ_READ, idx, d);
   endtask

   initial begin
      dcq_pkg::layout_type m;
      int                  phase_start;
      logic                held;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      // the upper words are cleared after reset while busy is high
      @(negedge clock);
      while (busy) @(negedge clock);
      set_layout(LAYOUT_OLD);

      m = dcq_pkg::layout_of(LAYOUT_OLD);
      send_word(dcq_pkg::REQ_READ, m.status, '0);
      send_word(dcq_pkg::REQ_READ, 0, '1);
      send_word(dcq_pkg::REQ_WRITE, 0, '1);
      send_word(dcq_pkg::REQ_READ, 0, '0);
      send_word(dcq_pkg::REQ_WRITE, BANK_WORDS - 1, '1);
      send_word(dcq_pkg::REQ_READ, BANK_WORDS - 1, '0);
      send_word(dcq_pkg::REQ_WRITE, BANK_WORDS, '1);
      send_word(dcq_pkg::REQ_READ, BANK_WORDS, '0);
      send_word(dcq_pkg::REQ_WRITE, TOP_INDEX, '1);
      send_word(dcq_pkg::REQ_READ, TOP_INDEX, '1);
      send_word(dcq_pkg::REQ_WRITE, m.endp, '1);
      send_word(dcq_pkg::REQ_READ, m.endp, '0);
      send_word(dcq_pkg::REQ_WRITE, m.ctrl, '1);
      send_word(dcq_pkg::REQ_WRITE, m.wrp, '1);
      send_word(dcq_pkg::REQ_READ, m.rdp, '0);
      send_word(dcq_pkg::REQ_WRITE, m.status, ~m.complete);
      send_word(dcq_pkg::REQ_WRITE, m.status, m.complete);
      send_word(dcq_pkg::REQ_WRITE, m.rdp, dcq_pkg::RDP_MAGIC);
      send_word(dcq_pkg::REQ_WRITE, m.wrp, '0);
      send_word(dcq_pkg::REQ_READ, m.status, '0);
      send_word(dcq_pkg::REQ_WRITE, m.rdp, dcq_pkg::RDP_MAGIC ^ 32'h1);

      set_layout(LAYOUT_NEW);
      m = dcq_pkg::layout_of(LAYOUT_NEW);
      send_word(dcq_pkg::REQ_WRITE, m.ctrl, '1);
      send_word(dcq_pkg::REQ_WRITE, m.wrp, 32'h0002_5A5A);
      send_word(dcq_pkg::REQ_READ, m.status, '0);
      send_word(dcq_pkg::REQ_WRITE, m.status, m.complete);

      held = 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         set_layout(p[0]);
         no_idle     = (p == 3);
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            if ($urandom_range(99) < 60) run_sequence();
            else run_single();
            // hold the sender until the bank has answered everything once mid-run
            if (p == 5 && !held && words_sent - phase_start >= PHASE_WORDS / 2) begin
               held = 1'b1;
               wait_all_results();
               repeat ($urandom_range(6, 1)) @(negedge clock);
            end
         end
      end

      wait_all_results();
      repeat (10) @(negedge clock);
      $display("sent %0d words, %0d results checked, over %0d random phases in both layouts",
               words_sent, checked_count, PHASES);
      $display("covered magic arm, write pointer kicks, status clears and out-of-bank access");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
